[design/lpht_pkg.sv]
// Package for the linear probing hash table.
// Holds widths, slot, action and status codes, and shared types; no dependencies.
package lpht_pkg;
  localparam int MAX_SLOTS_LOG2 = 10;
  localparam int KEY_BITS = 32;
  localparam int VALUE_BITS = 32;
  localparam int HASH_BITS = 32;
  localparam int DEPTH = 1 << MAX_SLOTS_LOG2;
  localparam int CNT_BITS = MAX_SLOTS_LOG2 + 1;
  localparam int IDX_BITS = MAX_SLOTS_LOG2;
  localparam int QUEUE_LOG2 = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_LOG2;

  typedef logic [1:0] action_t;
  localparam action_t ACT_LOOKUP = 2'd0;
  localparam action_t ACT_INSERT = 2'd1;
  localparam action_t ACT_DELETE = 2'd2;
  localparam action_t ACT_CLEAR = 2'd3;

  typedef logic [1:0] slot_st_t;
  localparam slot_st_t ST_EMPTY = 2'd0;
  localparam slot_st_t ST_LIVE = 2'd1;
  localparam slot_st_t ST_TOMB = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK = 2'd0;
  localparam status_t STAT_NOT_FOUND = 2'd1;
  localparam status_t STAT_FULL = 2'd2;

  typedef struct packed {
    action_t action;
    logic [KEY_BITS-1:0] key;
    logic [HASH_BITS-1:0] key_hash;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_READ, S_CHECK, S_WRITE, S_DONE
  } bstate_t;
endpackage

[design/lpht_front.sv]
// Front part: accepts requests and queues them for the probe engine.
// Depends on lpht_pkg.
module lpht_front import lpht_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic q_valid,
  input  logic q_ready,
  output req_t q_req
);
  req_t mem_r [QUEUE_DEPTH];
  logic [QUEUE_LOG2-1:0] wp_r, rp_r;
  logic [QUEUE_LOG2:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign in_ready = (cnt_r != QUEUE_DEPTH[QUEUE_LOG2:0]);
  assign q_valid = (cnt_r != '0);
  assign q_req = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_req;
  end
endmodule

[design/lpht_back.sv]
// Back part: probes the slot memories and carries out each request.
// Depends on lpht_pkg.
module lpht_back import lpht_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic [3:0] size_log2,
  input  logic q_valid,
  output logic q_ready,
  input  req_t q_req,
  output logic out_valid,
  input  logic out_ready,
  output status_t out_status,
  output logic [VALUE_BITS-1:0] out_value,
  output logic [CNT_BITS-1:0] out_count
);
  slot_st_t st_mem [DEPTH];
  logic [KEY_BITS-1:0] key_mem [DEPTH];
  logic [HASH_BITS-1:0] hash_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];

  bstate_t state_r, state_nxt;
  req_t req_r;
  logic [IDX_BITS-1:0] idx_r, idx_nxt, tomb_r, tomb_nxt, wa_r, wa_nxt;
  logic tomb_ok_r, tomb_ok_nxt;
  logic [IDX_BITS:0] n_r, n_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  status_t stat_r, stat_nxt;
  logic [VALUE_BITS-1:0] vout_r, vout_nxt;
  slot_st_t rd_st;
  logic [KEY_BITS-1:0] rd_key;
  logic [HASH_BITS-1:0] rd_hash;
  logic [VALUE_BITS-1:0] rd_val;
  logic we_st, we_kv, we_v;
  slot_st_t wst;
  logic [IDX_BITS-1:0] mask;
  logic [3:0] ul;
  logic [IDX_BITS:0] slots;
  logic out_valid_pend_r;

  always_comb begin
    ul = size_log2;
    if (ul < 4'd3) ul = 4'd3;
    if (ul > MAX_SLOTS_LOG2[3:0]) ul = MAX_SLOTS_LOG2[3:0];
    slots = (IDX_BITS+1)'(1) << ul;
    mask = IDX_BITS'(slots - 1'b1);
  end

  always_ff @(posedge clk) begin
    rd_st <= st_mem[idx_r];
    rd_key <= key_mem[idx_r];
    rd_hash <= hash_mem[idx_r];
    rd_val <= val_mem[idx_r];
    if (we_st) st_mem[wa_r] <= wst;
    if (we_kv) begin
      key_mem[wa_r] <= req_r.key;
      hash_mem[wa_r] <= req_r.key_hash;
    end
    if (we_v) val_mem[wa_r] <= req_r.value;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    tomb_nxt = tomb_r;
    tomb_ok_nxt = tomb_ok_r;
    wa_nxt = wa_r;
    n_nxt = n_r;
    cnt_nxt = cnt_r;
    stat_nxt = stat_r;
    vout_nxt = vout_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          stat_nxt = STAT_OK;
          vout_nxt = '0;
          tomb_ok_nxt = 1'b0;
          n_nxt = '0;
          if (q_req.action == ACT_CLEAR) begin
            wa_nxt = '0;
            cnt_nxt = '0;
            state_nxt = S_CLEAR;
          end else begin
            idx_nxt = IDX_BITS'(q_req.key_hash) & mask;
            state_nxt = S_READ;
          end
        end
      end
      S_CLEAR: begin
        wa_nxt = wa_r + 1'b1;
        if (wa_r == IDX_BITS'(DEPTH - 1)) state_nxt = S_DONE;
      end
      S_READ: state_nxt = S_CHECK;
      S_CHECK: begin
        state_nxt = S_DONE;
        if (rd_st == ST_EMPTY) begin
          if (req_r.action == ACT_INSERT) begin
            wa_nxt = tomb_ok_r ? tomb_r : idx_r;
            cnt_nxt = cnt_r + 1'b1;
            state_nxt = S_WRITE;
          end else begin
            stat_nxt = STAT_NOT_FOUND;
          end
        end else if (rd_st == ST_LIVE && rd_hash == req_r.key_hash && rd_key == req_r.key) begin
          wa_nxt = idx_r;
          case (req_r.action)
            ACT_LOOKUP: vout_nxt = rd_val;
            ACT_INSERT: state_nxt = S_WRITE;
            default: begin
              state_nxt = S_WRITE;
              if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
            end
          endcase
        end else begin
          if (rd_st == ST_TOMB && !tomb_ok_r) begin
            tomb_nxt = idx_r;
            tomb_ok_nxt = 1'b1;
          end
          if (n_r + 1'b1 == slots) begin
            if (req_r.action == ACT_INSERT) begin
              if (tomb_ok_nxt) begin
                wa_nxt = tomb_nxt;
                cnt_nxt = cnt_r + 1'b1;
                state_nxt = S_WRITE;
              end else begin
                stat_nxt = STAT_FULL;
              end
            end else begin
              stat_nxt = STAT_NOT_FOUND;
            end
          end else begin
            n_nxt = n_r + 1'b1;
            idx_nxt = (idx_r + 1'b1) & mask;
            state_nxt = S_READ;
          end
        end
      end
      S_WRITE: state_nxt = S_DONE;
      S_DONE: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state_r == S_IDLE);
    out_valid = (state_r == S_DONE);
    we_st = 1'b0;
    we_kv = 1'b0;
    we_v = 1'b0;
    wst = ST_EMPTY;
    case (state_r)
      S_CLEAR: we_st = 1'b1;
      S_WRITE: begin
        if (req_r.action == ACT_DELETE) begin
          we_st = 1'b1;
          wst = ST_TOMB;
        end else begin
          we_st = 1'b1;
          wst = ST_LIVE;
          we_kv = 1'b1;
          we_v = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_status = stat_r;
  assign out_value = vout_r;
  assign out_count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      wa_r <= '0;
      cnt_r <= '0;
      tomb_ok_r <= 1'b0;
      stat_r <= STAT_OK;
    end else begin
      state_r <= (state_r == S_CLEAR && state_nxt == S_DONE && !out_valid_pend_r) ?
                 S_IDLE : state_nxt;
      wa_r <= wa_nxt;
      cnt_r <= cnt_nxt;
      tomb_ok_r <= tomb_ok_nxt;
      stat_r <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_pend_r <= 1'b0;
    else if (state_r == S_IDLE && q_valid) out_valid_pend_r <= 1'b1;
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    tomb_r <= tomb_nxt;
    n_r <= n_nxt;
    vout_r <= vout_nxt;
    if (state_r == S_IDLE && q_valid) req_r <= q_req;
  end
endmodule

[design/linear_probe_hash_table.sv]
// Top level of the linear probing hash table.
// Depends on lpht_pkg, lpht_front and lpht_back.
//
// Requests arrive on the in_ stream: tuser carries the action (lookup, insert,
// delete, clear) and tdata carries key, key_hash and value. Each request gives
// one result on the out_ stream with status, value_out and entry_count.
// The front queue holds two requests. The back engine handles one request at
// a time: it reads each probed slot through a registered memory port in
// S_READ, checks it in S_CHECK, writes a slot in S_WRITE if needed and shows
// the result in S_DONE; it takes the next request once that result is taken.
// A clear sweeps all 1024 slots, one per cycle, then shows its result.
// After reset the engine runs the same clearing pass over the slot state memory
// before it takes a request; the queue still accepts two.
// When the receiver stalls, the result holds and the engine waits; the queue
// keeps accepting until full. cfg_wr_en writes size_log2 from cfg_wr_data.
module linear_probe_hash_table import lpht_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // Fields from bit 0: key[31:0], key_hash[63:32], value[95:64].
  input  logic [95:0] in_tdata,
  // Fields from bit 0: action[1:0].
  input  logic [1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // Fields from bit 0: status[1:0], value_out[33:2], entry_count[44:34].
  output logic [47:0] out_tdata,
  input  logic cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);
  logic [3:0] size_r;
  req_t in_req, q_req;
  logic q_valid, q_ready;
  status_t st;
  logic [VALUE_BITS-1:0] vo;
  logic [CNT_BITS-1:0] cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= 4'd3;
    else if (cfg_wr_en) size_r <= cfg_wr_data;
  end

  assign in_req.action = in_tuser;
  assign in_req.key = in_tdata[31:0];
  assign in_req.key_hash = in_tdata[63:32];
  assign in_req.value = in_tdata[95:64];

  lpht_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_req,
    .q_valid, .q_ready, .q_req
  );

  lpht_back u_back (
    .clk, .rst_n, .size_log2(size_r), .q_valid, .q_ready, .q_req,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_status(st),
    .out_value(vo), .out_count(cnt)
  );

  assign out_tdata = {3'b000, cnt, vo, st};

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tdata[44:34] <= 11'd1024) else $error("entry count too large");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3) else $error("bad status");
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != STAT_OK |-> out_tdata[33:2] == '0)
    else $error("value on failure");
`endif
endmodule
